// ===== design/vqd_pkg.sv =====
package vqd_pkg;

   localparam int CODEBOOK_BYTES_DEF  = 32768;
   localparam int FRAME_ADDR_BITS_DEF = 20;

   localparam logic [7:0] FILL_MARK = 8'h0F;
   localparam int ENTRY_BYTES   = 8;
   localparam int WORD_BYTES    = 4;
   localparam int LANE_SEL_BITS = $clog2(ENTRY_BYTES);

   // Widest entry row index, for the largest codebook of 65536 bytes.
   localparam int ENTRY_ROW_MAX_BITS = 13;
   localparam int INDEX_SPAN         = 1 << 16;
   localparam int ADDR_CALC_BITS     = 22;
   localparam int CSR_DATA_BITS      = 11;

   localparam logic [1:0] KIND_FULL  = 2'd0;
   localparam logic [1:0] KIND_PART  = 2'd1;
   localparam logic [1:0] KIND_BLOCK = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] CSR_BLOCKS_PER_ROW = 2'd0;
   localparam logic [1:0] CSR_BLOCK_ROWS     = 2'd1;
   localparam logic [1:0] CSR_LINE_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_GROUP_SIZE     = 2'd3;

   localparam logic [8:0]  BLOCKS_PER_ROW_RST = 9'd80;
   localparam logic [9:0]  BLOCK_ROWS_RST     = 10'd100;
   localparam logic [10:0] LINE_WIDTH_RST     = 11'd320;
   localparam logic [7:0]  GROUP_SIZE_RST     = 8'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [14:0] codebook_address;
      logic        chunk_mark;
      logic [7:0]  pointer_low;
      logic [7:0]  pointer_high;
   } req_type;

   typedef struct packed {
      logic [19:0] pixel_address;
      logic [31:0] pixel_word;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic                          in_range;
      logic                          mark;
      logic [7:0]                    data_byte;
      logic [14:0]                   codebook_address;
      logic                          solid;
      logic [7:0]                    colour;
      logic [ENTRY_ROW_MAX_BITS-1:0] entry_row;
   } cmd_type;

endpackage

// ===== design/vqd_ram.sv =====
module vqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [WIDTH-1:0]     wr_data,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/vqd_queue.sv =====
module vqd_queue
   import vqd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== design/vqd_front.sv =====
module vqd_front
   import vqd_pkg::*;
#(
   parameter int CODEBOOK_BYTES = CODEBOOK_BYTES_DEF
) (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    init_busy,
   output logic    q_valid,
   input  logic    q_ready,
   output cmd_type q_cmd
);

   localparam int ROWS      = CODEBOOK_BYTES / ENTRY_BYTES;
   localparam int RED_STEPS = $clog2((INDEX_SPAN + ROWS - 1) / ROWS);

   logic [17:0] entry_rem;

   // The entry index wraps modulo the number of entries: a short chain of
   // compare-and-subtract steps against shifted copies of the entry count.
   always_comb begin
      entry_rem = {2'b00, req_payload.pointer_high, req_payload.pointer_low};
      for (int i = RED_STEPS - 1; i >= 0; i--) begin
         if (entry_rem >= 18'(ROWS << i)) begin
            entry_rem = entry_rem - 18'(ROWS << i);
         end
      end
   end

   assign req_ready = q_ready && !init_busy;
   assign q_valid   = req_valid && !init_busy && (req_payload.kind != KIND_NONE);

   always_comb begin
      q_cmd.kind             = req_payload.kind;
      q_cmd.in_range         = ({2'b00, req_payload.codebook_address} < 17'(CODEBOOK_BYTES));
      q_cmd.mark             = req_payload.chunk_mark;
      q_cmd.data_byte        = req_payload.data_byte;
      q_cmd.codebook_address = req_payload.codebook_address;
      q_cmd.solid            = (req_payload.pointer_high == FILL_MARK);
      q_cmd.colour           = req_payload.pointer_low;
      q_cmd.entry_row        = entry_rem[ENTRY_ROW_MAX_BITS-1:0];
   end

endmodule

// ===== design/vqd_back.sv =====
module vqd_back
   import vqd_pkg::*;
#(
   parameter int CODEBOOK_BYTES  = CODEBOOK_BYTES_DEF,
   parameter int FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  cmd_type                  q_cmd,
   output logic                     init_busy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_payload
);

   localparam int ROWS          = CODEBOOK_BYTES / ENTRY_BYTES;
   localparam int ROW_BITS      = $clog2(ROWS);
   localparam int RAM_ADDR_BITS = ROW_BITS + 1;
   localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
   localparam int FILL_BITS     = $clog2(CODEBOOK_BYTES + 1);
   localparam logic [ADDR_CALC_BITS-1:0] ADDR_MASK =
      (FRAME_ADDR_BITS >= ADDR_CALC_BITS) ? {ADDR_CALC_BITS{1'b1}} :
      ((ADDR_CALC_BITS'(1) << FRAME_ADDR_BITS) - ADDR_CALC_BITS'(1));

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DATA  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [RAM_ADDR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                     clr_bank_ff, clr_bank_in;
   logic                     active_ff, active_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [7:0]               parts_ff, parts_in;
   logic [7:0]               col_ff, col_in;
   logic [8:0]               row_ff, row_in;
   logic [19:0]              prod_ff, prod_in;
   logic [7:0]               colour_ff, colour_in;
   logic [8:0]               bpr_ff;
   logic [9:0]               rows_ff;
   logic [10:0]              lw_ff;
   logic [7:0]               group_ff;
   logic                     out_vld_ff, out_vld_in;
   logic                     hold_vld_ff, hold_vld_in;
   rsp_type                  out_ff, out_in;
   rsp_type                  hold_ff, hold_in;

   logic [ENTRY_BYTES-1:0]   ram_wr;
   logic                     ram_rd;
   logic [RAM_ADDR_BITS-1:0] ram_addr;
   logic [7:0]               ram_wdata;
   logic [7:0]               rd_byte [ENTRY_BYTES];

   logic [15:0]              caddr_ext;
   logic [8:0]               bpr_eff;
   logic [9:0]               rows_eff;
   logic                     col_wrap, row_wrap;
   logic                     can_load, load;
   logic [31:0]              top_word, bottom_word;
   logic [ADDR_CALC_BITS-1:0] top_sum, bottom_sum;

   // Codebook storage: one byte lane per entry byte, bank select on the top address bit.
   for (genvar g = 0; g < ENTRY_BYTES; g++) begin : g_lane
      vqd_ram #(
         .WIDTH (8),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr[g]),
         .rd_en   (ram_rd),
         .addr    (ram_addr),
         .wr_data (ram_wdata),
         .rd_data (rd_byte[g])
      );
   end

   assign init_busy = (state_ff == ST_INIT);
   assign caddr_ext = {1'b0, q_cmd.codebook_address};
   assign prod_in   = row_ff * lw_ff;

   assign bpr_eff  = (bpr_ff == 9'd0) ? 9'd1 : ((bpr_ff > 9'd256) ? 9'd256 : bpr_ff);
   assign rows_eff = (rows_ff == 10'd0) ? 10'd1 : ((rows_ff > 10'd512) ? 10'd512 : rows_ff);
   assign col_wrap = (({1'b0, col_ff} + 9'd1) >= bpr_eff);
   assign row_wrap = (({1'b0, row_ff} + 10'd1) >= rows_eff);

   // A new pair fits when the output stage is empty or drains its last beat now.
   assign can_load = !out_vld_ff || (rsp_ready && !hold_vld_ff);

   assign top_word = (state_ff == ST_DATA) ?
      {rd_byte[3], rd_byte[2], rd_byte[1], rd_byte[0]} : {WORD_BYTES{colour_ff}};
   assign bottom_word = (state_ff == ST_DATA) ?
      {rd_byte[7], rd_byte[6], rd_byte[5], rd_byte[4]} : {WORD_BYTES{colour_ff}};
   assign top_sum    = {1'b0, prod_ff, 1'b0} + {12'd0, col_ff, 2'b00};
   assign bottom_sum = top_sum + {11'd0, lw_ff};

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_bank_in = clr_bank_ff;
      active_in   = active_ff;
      fill_in     = fill_ff;
      parts_in    = parts_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      colour_in   = colour_ff;
      q_ready     = 1'b0;
      load        = 1'b0;
      ram_wr      = '0;
      ram_rd      = 1'b0;
      ram_addr    = clr_cnt_ff;
      ram_wdata   = 8'd0;

      case (state_ff)
         ST_INIT: begin
            ram_wr     = '1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RAM_ADDR_BITS'(RAM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               case (q_cmd.kind)
                  KIND_FULL: begin
                     if (q_cmd.in_range) begin
                        ram_wr    = ENTRY_BYTES'(1) << caddr_ext[LANE_SEL_BITS-1:0];
                        ram_addr  = {active_ff,
                                     caddr_ext[ROW_BITS+LANE_SEL_BITS-1:LANE_SEL_BITS]};
                        ram_wdata = q_cmd.data_byte;
                     end
                     if (q_cmd.mark) begin
                        fill_in  = '0;
                        parts_in = 8'd0;
                     end
                  end
                  KIND_PART: begin
                     if (fill_ff < FILL_BITS'(CODEBOOK_BYTES)) begin
                        ram_wr    = ENTRY_BYTES'(1) << fill_ff[LANE_SEL_BITS-1:0];
                        ram_addr  = {~active_ff,
                                     fill_ff[ROW_BITS+LANE_SEL_BITS-1:LANE_SEL_BITS]};
                        ram_wdata = q_cmd.data_byte;
                        fill_in   = fill_ff + 1'b1;
                     end
                     if (q_cmd.mark && (parts_ff != 8'd255)) begin
                        parts_in = parts_ff + 8'd1;
                     end
                  end
                  KIND_BLOCK: begin
                     if (q_cmd.solid) begin
                        colour_in = q_cmd.colour;
                        state_in  = ST_LOAD;
                     end else begin
                        ram_rd   = 1'b1;
                        ram_addr = {active_ff, q_cmd.entry_row[ROW_BITS-1:0]};
                        state_in = ST_DATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DATA, ST_LOAD: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (col_wrap) begin
                  col_in = 8'd0;
                  if (row_wrap) begin
                     row_in = 9'd0;
                     // Frame end with enough parts: swap banks and wipe the old one.
                     if (parts_ff >= group_ff) begin
                        active_in   = ~active_ff;
                        fill_in     = '0;
                        parts_in    = 8'd0;
                        clr_bank_in = active_ff;
                        clr_cnt_in  = '0;
                        state_in    = ST_CLEAR;
                     end
                  end else begin
                     row_in = row_ff + 9'd1;
                  end
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         ST_CLEAR: begin
            ram_wr     = '1;
            ram_addr   = {clr_bank_ff, clr_cnt_ff[ROW_BITS-1:0]};
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff[ROW_BITS-1:0] == ROW_BITS'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      hold_vld_in = hold_vld_ff;
      out_in      = out_ff;
      hold_in     = hold_ff;
      if (load) begin
         out_vld_in            = 1'b1;
         hold_vld_in           = 1'b1;
         out_in.pixel_address  = top_sum[19:0] & ADDR_MASK[19:0];
         out_in.pixel_word     = top_word;
         out_in.last           = 1'b0;
         hold_in.pixel_address = bottom_sum[19:0] & ADDR_MASK[19:0];
         hold_in.pixel_word    = bottom_word;
         hold_in.last          = 1'b1;
      end else if (out_vld_ff && rsp_ready) begin
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            hold_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         clr_cnt_ff  <= '0;
         clr_bank_ff <= 1'b0;
         active_ff   <= 1'b0;
         fill_ff     <= '0;
         parts_ff    <= 8'd0;
         col_ff      <= 8'd0;
         row_ff      <= 9'd0;
         out_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
         bpr_ff      <= BLOCKS_PER_ROW_RST;
         rows_ff     <= BLOCK_ROWS_RST;
         lw_ff       <= LINE_WIDTH_RST;
         group_ff    <= GROUP_SIZE_RST;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         clr_bank_ff <= clr_bank_in;
         active_ff   <= active_in;
         fill_ff     <= fill_in;
         parts_ff    <= parts_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         out_vld_ff  <= out_vld_in;
         hold_vld_ff <= hold_vld_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BLOCKS_PER_ROW: bpr_ff   <= csr_wdata[8:0];
               CSR_BLOCK_ROWS:     rows_ff  <= csr_wdata[9:0];
               CSR_LINE_WIDTH:     lw_ff    <= csr_wdata[10:0];
               CSR_GROUP_SIZE:     group_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      colour_ff <= colour_in;
      out_ff    <= out_in;
      hold_ff   <= hold_in;
   end

endmodule

// ===== design/vq_block_frame_decoder.sv =====
// A block pointer beat reaches the output register through the queue slot and the back
// end as its top-row word; the hold register passes on the bottom-row word once taken.
// Codebook byte beats are written in the idle state. A block pointer holds the back end
// until its word pair loads, a frame-end bank swap until the old bank's rows are wiped.
// Reset (synchronous) wipes both banks, 2 * 2^clog2(CODEBOOK_BYTES/8) entry rows
// (8192 at default), with req_ready low throughout; configuration writes are taken.
module vq_block_frame_decoder
   import vqd_pkg::*;
#(
   parameter int CODEBOOK_BYTES  = CODEBOOK_BYTES_DEF,
   parameter int FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic    init_busy;
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   vqd_front #(
      .CODEBOOK_BYTES (CODEBOOK_BYTES)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .init_busy   (init_busy),
      .q_valid     (fq_valid),
      .q_ready     (fq_ready),
      .q_cmd       (fq_cmd)
   );

   vqd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_cmd   (qb_cmd)
   );

   vqd_back #(
      .CODEBOOK_BYTES  (CODEBOOK_BYTES),
      .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_valid     (qb_valid),
      .q_ready     (qb_ready),
      .q_cmd       (qb_cmd),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
